// File: hdl/tach_pkg.sv
package tach_pkg;

   localparam int GAP_W   = 8;
   localparam int TALLY_W = 16;
   localparam int AGE_W   = 16;
   localparam int RPM_W   = 16;
   localparam int DEB_W   = 8;
   localparam int SMP_W   = 16;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   localparam int DEF_WINDOW   = 10;
   localparam int DEF_PPR      = 1;
   localparam int RPM_PER_PPS  = 60;

   localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd10;
   localparam logic [SMP_W-1:0] SAMPLE_RST   = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_SAMPLE   = 1'b1
   } csr_idx_type;

   // the current tally and whether it closes a sample period, handed from the tally logic to the ring
   typedef struct packed {
      logic               due;
      logic [TALLY_W-1:0] tally;
   } sample_type;

endpackage

// File: hdl/tach_front.sv
module tach_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic                         edge_req,
   input  logic [tach_pkg::DEB_W-1:0]   debounce_ms,
   input  logic [tach_pkg::SMP_W-1:0]   sample_ms,
   output tach_pkg::sample_type         sample,
   output logic [tach_pkg::TALLY_W-1:0] last_tally
);
   import tach_pkg::*;

   logic [GAP_W-1:0]   gap_ff, gap_in, gap_inc;
   logic [TALLY_W-1:0] tally_ff, tally_in, tally_inc;
   logic [TALLY_W-1:0] hold_ff, hold_in;
   logic [AGE_W-1:0]   age_ff, age_in;
   logic [AGE_W:0]     age_inc;
   logic               take, due;

   always_comb begin
      gap_inc   = (gap_ff == {GAP_W{1'b1}}) ? gap_ff : gap_ff + 1'b1;
      take      = edge_req && (gap_inc > debounce_ms);
      gap_in    = take ? '0 : gap_inc;
      tally_inc = (take && (tally_ff != {TALLY_W{1'b1}})) ? tally_ff + 1'b1 : tally_ff;
      age_inc   = {1'b0, age_ff} + 1'b1;
      // a zero period compares like one: the incremented age is never below it
      due       = (age_inc >= {1'b0, sample_ms}) || age_inc[AGE_W];
      age_in    = due ? '0 : age_inc[AGE_W-1:0];
      tally_in  = due ? '0 : tally_inc;
      hold_in   = due ? tally_inc : hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= '0;
         tally_ff <= '0;
         hold_ff  <= '0;
         age_ff   <= '0;
      end else if (step) begin
         gap_ff   <= gap_in;
         tally_ff <= tally_in;
         hold_ff  <= hold_in;
         age_ff   <= age_in;
      end
   end

   assign sample.due   = due;
   assign sample.tally = tally_inc;
   assign last_tally   = hold_ff;

endmodule

// File: hdl/tach_window.sv
module tach_window #(
   parameter int WINDOW = tach_pkg::DEF_WINDOW,
   parameter int SUM_W  = $clog2(WINDOW * 65535 + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tach_pkg::sample_type sample,
   output logic [SUM_W-1:0]     window_sum
);
   import tach_pkg::*;

   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic [TALLY_W-1:0] ring_mem [WINDOW];
   logic [WINDOW-1:0]  valid_ff;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TALLY_W-1:0] rd_ff, byp_data_ff, oldest;
   logic               rdv_ff, byp_ff;
   logic               push;

   assign push = step && sample.due;

   always_comb begin
      pos_in = (pos_ff == AW'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
      if (byp_ff)
         oldest = byp_data_ff;
      else if (rdv_ff)
         oldest = rd_ff;
      else
         oldest = '0;
      sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample.tally);
   end

   always_ff @(posedge clock) begin
      if (push)
         ring_mem[pos_ff] <= sample.tally;
   end

   // prefetch the entry that the next sample replaces
   always_ff @(posedge clock) begin
      if (push) begin
         rd_ff       <= ring_mem[pos_in];
         byp_data_ff <= sample.tally;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pos_ff   <= '0;
         sum_ff   <= '0;
         rdv_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else if (push) begin
         valid_ff[pos_ff] <= 1'b1;
         pos_ff           <= pos_in;
         sum_ff           <= sum_in;
         rdv_ff           <= valid_ff[pos_in];
         byp_ff           <= (pos_in == pos_ff);
      end
   end

   assign window_sum = sum_ff;

endmodule

// File: hdl/tach_out.sv
module tach_out #(
   parameter int PPR   = tach_pkg::DEF_PPR,
   parameter int SUM_W = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         take,
   input  logic                         sampled,
   input  logic [SUM_W-1:0]             window_sum,
   input  logic [tach_pkg::TALLY_W-1:0] last_tally,
   output logic                         valid,
   output logic [tach_pkg::RPM_W-1:0]   rpm,
   output logic [tach_pkg::TALLY_W-1:0] tally,
   output logic                         sampled_out
);
   import tach_pkg::*;

   localparam int PROD_W = SUM_W + $clog2(RPM_PER_PPS + 1);

   // Divide by PPR through a reciprocal. Products of 65536*PPR and above
   // saturate, so the rest fit RPM_W+6 bits (PPR is at most 64) and the
   // rounded-up reciprocal with a shift of QUOT_W+6 gives the exact quotient.
   localparam int              QUOT_W    = RPM_W + 6;
   localparam int              RECIP_SH  = QUOT_W + 6;
   localparam int              RECIP_W   = RECIP_SH + 1;
   localparam int              WIDE_W    = QUOT_W + RECIP_W;
   localparam longint unsigned RECIP     =
      ((longint'(1) << RECIP_SH) + longint'(PPR) - 1) / longint'(PPR);
   localparam longint unsigned SAT_LIMIT = longint'(PPR) << RPM_W;

   logic [PROD_W-1:0] prod;
   logic [WIDE_W-1:0] quot_wide;
   logic [RPM_W-1:0]  rpm_sat;
   logic              valid_ff, valid_in;
   logic [RPM_W-1:0]  rpm_ff;
   logic [TALLY_W-1:0] tally_ff;
   logic              sampled_ff;

   always_comb begin
      prod      = PROD_W'(window_sum) * PROD_W'(RPM_PER_PPS);
      quot_wide = WIDE_W'(prod[QUOT_W-1:0]) * WIDE_W'(RECIP);
      rpm_sat   = (prod >= PROD_W'(SAT_LIMIT)) ? {RPM_W{1'b1}}
                                                : quot_wide[RECIP_SH +: RPM_W];
      if (load)
         valid_in = 1'b1;
      else if (take)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rpm_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (load && sampled)
            rpm_ff <= rpm_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tally_ff   <= last_tally;
         sampled_ff <= sampled;
      end
   end

   assign valid       = valid_ff;
   assign rpm         = rpm_ff;
   assign tally       = tally_ff;
   assign sampled_out = sampled_ff;

endmodule

// File: hdl/tachometer_moving_average.sv
// A request accepted passes the update stage register and then the response register
// before its response shows.
// Throughput: one request per cycle; req_tready falls only while both the
// update stage and the response register hold items that rsp_tready keeps back.
// The pulse, sample and ring update sit in the first stage, the rpm scaling
// (times 60, over PPR, saturate) in the second, ahead of the response register.
// Reset (synchronous, active high) clears counters, ring valid bits, sum and rpm at once.
module tachometer_moving_average #(
   parameter int WINDOW = tach_pkg::DEF_WINDOW,
   parameter int PPR    = tach_pkg::DEF_PPR
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tach_pkg::REQ_DATA_W-1:0] req_tdata,  // [0] edge_req, rest zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tach_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [15:0] rpm, [31:16] last_tally
   output logic                            rsp_tuser,  // [0] sampled
   input  logic                            csr_we,
   input  logic [tach_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [tach_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tach_pkg::*;

   localparam int SUM_W = $clog2(WINDOW * 65535 + 1);

   // configuration registers; the user writes them only while the block is idle, unenforced here
   logic [DEB_W-1:0] debounce_ff;
   logic [SMP_W-1:0] sample_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= DEBOUNCE_RST;
         sample_ms_ff <= SAMPLE_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_DEBOUNCE: begin
               debounce_ff <= csr_wdata[DEB_W-1:0];
            end
            CSR_SAMPLE: begin
               sample_ms_ff <= csr_wdata[SMP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake: the update stage holds one request's sample flag while the
   // response register is busy; state has already advanced for that request
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_sampled_ff;
   logic       out_free, accept, advance, rsp_valid;
   sample_type sample;

   assign out_free   = !rsp_valid || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign advance    = s1_valid_ff && out_free;

   always_comb begin
      if (accept)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept)
         s1_sampled_ff <= sample.due;
   end

   // debounce, tally and sample timer
   logic [TALLY_W-1:0] last_tally;

   tach_front u_front (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .edge_req    (req_tdata[0]),
      .debounce_ms (debounce_ff),
      .sample_ms   (sample_ms_ff),
      .sample      (sample),
      .last_tally  (last_tally)
   );

   // ring of tallies with its running sum
   logic [SUM_W-1:0] window_sum;

   tach_window #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .sample     (sample),
      .window_sum (window_sum)
   );

   // rpm scaling and response register; sum and tally hold reflect the
   // request in the update stage, since nothing new is accepted past it
   logic [RPM_W-1:0]   rpm;
   logic [TALLY_W-1:0] rsp_tally;
   logic               rsp_sampled;

   tach_out #(
      .PPR   (PPR),
      .SUM_W (SUM_W)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .take        (rsp_tready),
      .sampled     (s1_sampled_ff),
      .window_sum  (window_sum),
      .last_tally  (last_tally),
      .valid       (rsp_valid),
      .rpm         (rpm),
      .tally       (rsp_tally),
      .sampled_out (rsp_sampled)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {rsp_tally, rpm};
   assign rsp_tuser  = rsp_sampled;

endmodule
